/* hw/rtl/rdt_pkg.sv */
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared codes and types for the triangle residual distribution block.
// ----------------------------------------------------------------------------
package rdt_pkg;

    localparam int IO_BITS      = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VELOCITY_X  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VELOCITY_Y  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCHEME_MODE = 2'd2;

    localparam logic SCHEME_N   = 1'b0;
    localparam logic SCHEME_LDA = 1'b1;

    // clip_early: input, normal, k and sum stages; clip_late: everything after
    typedef struct packed {
        logic degen;
        logic clip_early;
        logic clip_late;
    } rdt_flags_t;

endpackage

/* hw/rtl/rdt_fmul.sv */
// ----------------------------------------------------------------------------
// rdt_fmul
// Fixed-point product, rounded to nearest (ties away from zero), saturated.
// ----------------------------------------------------------------------------
module rdt_fmul import rdt_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] p,
    output logic                clip
);

    localparam int PB = 2 * W;
    localparam int RB = 2 * W + 1 - F;

    logic          neg;
    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic [PB-1:0] prod;
    logic [PB:0]   rnd;
    logic [RB-1:0] r;
    logic [W:0]    lim;
    logic [W-1:0]  mag;

    always_comb
    begin
        neg  = a[W-1] ^ b[W-1];
        ma   = a[W-1] ? W'(-a) : W'(a);
        mb   = b[W-1] ? W'(-b) : W'(b);
        prod = PB'(ma) * PB'(mb);
        rnd  = {1'b0, prod} + ((PB+1)'(1) << (F - 1));
        r    = rnd[PB:F];
        lim  = ((W+1)'(1) << (W - 1)) - (W+1)'(!neg);
        if (r > RB'(lim))
        begin
            clip = 1'b1;
            mag  = lim[W-1:0];
        end
        else
        begin
            clip = 1'b0;
            mag  = r[W-1:0];
        end
        p = neg ? $signed(-mag) : $signed(mag);
    end

endmodule

/* hw/rtl/rdt_lane.sv */
// ----------------------------------------------------------------------------
// rdt_lane
// One vertex lane: edge normal, two velocity products, inflow parameter k.
// ----------------------------------------------------------------------------
module rdt_lane import rdt_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] vx,
    input  logic signed [W-1:0] vy,
    input  logic signed [W-1:0] xj,
    input  logic signed [W-1:0] yj,
    input  logic signed [W-1:0] xl,
    input  logic signed [W-1:0] yl,
    output logic signed [W-1:0] k,
    output logic                clip
);

    localparam longint HI = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam longint LO = -HI - 64'sd1;

    function automatic logic [W:0] sat_w(input logic signed [W+2:0] v);
        logic [W:0] r;
        if (v > HI)
            r = {1'b1, W'(HI)};
        else if (v < LO)
            r = {1'b1, W'(LO)};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    logic [W:0]          nx_s, ny_s, k_s;
    logic signed [W-1:0] nx_reg, ny_reg, px_reg, py_reg, k_reg;
    logic                c0_reg, c1_reg, c2_reg;
    logic signed [W-1:0] px, py;
    logic                cpx, cpy;
    logic signed [W:0]   e, h;

    assign nx_s = sat_w((W+3)'(yj) - (W+3)'(yl));
    assign ny_s = sat_w((W+3)'(xl) - (W+3)'(xj));

    rdt_fmul #(.W(W), .F(F)) u_mx (.a(vx), .b(nx_reg), .p(px), .clip(cpx));
    rdt_fmul #(.W(W), .F(F)) u_my (.a(vy), .b(ny_reg), .p(py), .clip(cpy));

    // halve, truncating toward zero
    always_comb
    begin
        e   = (W+1)'(px_reg) + (W+1)'(py_reg);
        h   = (e + $signed({{W{1'b0}}, e[W]})) >>> 1;
        k_s = sat_w((W+3)'(h));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= nx_s[W-1:0];
            ny_reg <= ny_s[W-1:0];
            c0_reg <= nx_s[W] | ny_s[W];
            px_reg <= px;
            py_reg <= py;
            c1_reg <= c0_reg | cpx | cpy;
            k_reg  <= k_s[W-1:0];
            c2_reg <= c1_reg | k_s[W];
        end
    end

    assign k    = k_reg;
    assign clip = c2_reg;

endmodule

/* hw/rtl/rdt_merge.sv */
// ----------------------------------------------------------------------------
// rdt_merge
// Combines the three lanes: positive sum, degenerate test, weighted sums.
// ----------------------------------------------------------------------------
module rdt_merge import rdt_pkg::*; #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int NB = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  logic signed [W-1:0] k [3],
    input  logic signed [W-1:0] u [3],
    input  logic                clip_in,
    output logic                vld_out,
    output logic [NB-1:0]       num,
    output logic [W-2:0]        den,
    output logic signed [W-1:0] kp_out [3],
    output logic signed [W-1:0] u_out [3],
    output logic signed [W-1:0] sneg,
    output logic signed [W-1:0] spos,
    output rdt_flags_t          flags
);

    localparam longint HI = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam longint LO = -HI - 64'sd1;

    function automatic logic [W:0] sat_w(input logic signed [W+2:0] v);
        logic [W:0] r;
        if (v > HI)
            r = {1'b1, W'(HI)};
        else if (v < LO)
            r = {1'b1, W'(LO)};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    logic signed [W-1:0] kp [3];
    logic signed [W-1:0] km [3];
    logic signed [W-1:0] mn [3];
    logic signed [W-1:0] mp [3];
    logic [2:0]          cmn, cmp;
    logic [W:0]          s_s, sn_s, sp_s;

    logic                vld_reg;
    logic signed [W-1:0] s_reg;
    logic signed [W-1:0] kp_reg [3];
    logic signed [W-1:0] u_reg [3];
    logic signed [W-1:0] mn_reg [3];
    logic signed [W-1:0] mp_reg [3];
    rdt_flags_t          flags_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_prod
        assign kp[i] = (k[i] > 0) ? k[i] : '0;
        assign km[i] = (k[i] < 0) ? k[i] : '0;
        rdt_fmul #(.W(W), .F(F)) u_mn (.a(km[i]), .b(u[i]), .p(mn[i]), .clip(cmn[i]));
        rdt_fmul #(.W(W), .F(F)) u_mp (.a(kp[i]), .b(u[i]), .p(mp[i]), .clip(cmp[i]));
    end

    assign s_s = sat_w((W+3)'(kp[0]) + (W+3)'(kp[1]) + (W+3)'(kp[2]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg                <= s_s[W-1:0];
            flags_reg.degen      <= (s_s[W-1:0] == '0);
            flags_reg.clip_early <= clip_in | s_s[W];
            flags_reg.clip_late  <= (|cmn) | (|cmp);
            kp_reg               <= kp;
            u_reg                <= u;
            mn_reg               <= mn;
            mp_reg               <= mp;
        end
    end

    assign sn_s = sat_w((W+3)'(mn_reg[0]) + (W+3)'(mn_reg[1]) + (W+3)'(mn_reg[2]));
    assign sp_s = sat_w((W+3)'(mp_reg[0]) + (W+3)'(mp_reg[1]) + (W+3)'(mp_reg[2]));

    always_comb
    begin
        flags           = flags_reg;
        flags.clip_late = flags_reg.clip_late | sn_s[W] | sp_s[W];
    end

    // 2^(2F) rounded quotient: add half the divisor to the numerator
    assign num     = (NB'(1) << (2 * F)) + NB'(s_reg[W-2:1]);
    assign den     = flags_reg.degen ? (W-1)'(1) : s_reg[W-2:0];
    assign sneg    = sn_s[W-1:0];
    assign spos    = sp_s[W-1:0];
    assign kp_out  = kp_reg;
    assign u_out   = u_reg;
    assign vld_out = vld_reg;

endmodule

/* hw/rtl/rdt_div.sv */
// ----------------------------------------------------------------------------
// rdt_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module rdt_div import rdt_pkg::*; #(
    parameter int NB = 33,
    parameter int DW = 31,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  logic [NB-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] pay,
    output logic          vld_out,
    output logic [NB-1:0] quo,
    output logic [PW-1:0] pay_out
);

    logic [NB-1:0] vld_reg;
    logic [DW-1:0] rem_reg [NB];
    logic [NB-1:0] nq_reg  [NB];
    logic [DW-1:0] den_reg [NB];
    logic [PW-1:0] pay_reg [NB];

    for (genvar t = 0; t < NB; t++)
    begin : g_stage
        logic          vld_p;
        logic [DW-1:0] rem_p;
        logic [NB-1:0] nq_p;
        logic [DW-1:0] den_p;
        logic [PW-1:0] pay_p;
        logic [DW:0]   sh;
        logic          ge;

        if (t == 0)
        begin : g_first
            assign vld_p = vld_in;
            assign rem_p = '0;
            assign nq_p  = num;
            assign den_p = den;
            assign pay_p = pay;
        end
        else
        begin : g_next
            assign vld_p = vld_reg[t-1];
            assign rem_p = rem_reg[t-1];
            assign nq_p  = nq_reg[t-1];
            assign den_p = den_reg[t-1];
            assign pay_p = pay_reg[t-1];
        end

        assign sh = {rem_p, nq_p[NB-1]};
        assign ge = (sh >= {1'b0, den_p});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[t] <= 1'b0;
            else if (en)
                vld_reg[t] <= vld_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[t] <= ge ? DW'(sh - {1'b0, den_p}) : DW'(sh);
                nq_reg[t]  <= {nq_p[NB-2:0], ge};
                den_reg[t] <= den_p;
                pay_reg[t] <= pay_p;
            end
        end
    end

    assign vld_out = vld_reg[NB-1];
    assign quo     = nq_reg[NB-1];
    assign pay_out = pay_reg[NB-1];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NB-1] |-> (rem_reg[NB-1] < den_reg[NB-1]))
        else $error("divider remainder not below divisor");

endmodule

/* hw/rtl/rdt_dist.sv */
// ----------------------------------------------------------------------------
// rdt_dist
// Inflow/outflow, per-node distribution (N or LDA) and output register.
// ----------------------------------------------------------------------------
module rdt_dist import rdt_pkg::*; #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int NB = 33
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      mode,
    input  logic                      vld_in,
    input  logic [NB-1:0]             q,
    input  logic signed [W-1:0]       kp [3],
    input  logic signed [W-1:0]       u [3],
    input  logic signed [W-1:0]       sneg,
    input  logic signed [W-1:0]       spos,
    input  rdt_flags_t                flags_in,
    output logic                      vld_out,
    output logic signed [IO_BITS-1:0] upd [3],
    output logic                      degenerate,
    output logic                      saturated
);

    localparam longint HI  = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam longint LO  = -HI - 64'sd1;
    localparam int     OB  = (W > IO_BITS) ? IO_BITS : W;
    localparam longint OHI = (64'sd1 <<< (OB - 1)) - 64'sd1;
    localparam longint OLO = -OHI - 64'sd1;

    function automatic logic [W:0] sat_w(input logic signed [W+2:0] v);
        logic [W:0] r;
        if (v > HI)
            r = {1'b1, W'(HI)};
        else if (v < LO)
            r = {1'b1, W'(LO)};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // stage 1: N, inflow, outflow
    logic                n_clip;
    logic signed [W-1:0] n;
    logic signed [W-1:0] fin, fout;
    logic                cfin, cfout;
    logic [W:0]          inf_s;

    assign n_clip = ($signed({1'b0, q}) > HI);
    assign n      = n_clip ? W'(HI) : W'(q);

    rdt_fmul #(.W(W), .F(F)) u_fin  (.a(n), .b(sneg), .p(fin),  .clip(cfin));
    rdt_fmul #(.W(W), .F(F)) u_fout (.a(n), .b(spos), .p(fout), .clip(cfout));

    assign inf_s = sat_w(-((W+3)'(fin)));

    logic [2:0]          vld_reg;
    logic signed [W-1:0] inf_reg, outf_reg;
    logic signed [W-1:0] kp1_reg [3];
    logic signed [W-1:0] u1_reg [3];
    rdt_flags_t          f1_reg;

    // stage 2: per-node factor
    logic [W:0]          diff_s;
    logic [W:0]          un_s [3];
    logic signed [W-1:0] t [3];
    logic                c2;
    logic signed [W-1:0] t_reg [3];
    logic signed [W-1:0] kp2_reg [3];
    rdt_flags_t          f2_reg;

    always_comb
    begin
        diff_s = sat_w((W+3)'(outf_reg) - (W+3)'(inf_reg));
        c2     = diff_s[W];
        for (int i = 0; i < 3; i++)
        begin
            un_s[i] = sat_w((W+3)'(u1_reg[i]) - (W+3)'(inf_reg));
            if (mode == SCHEME_LDA)
                t[i] = diff_s[W-1:0];
            else
            begin
                t[i] = un_s[i][W-1:0];
                c2   = c2 | un_s[i][W];
            end
        end
    end

    // stage 3: final products, narrowed to the output width
    logic signed [W-1:0]  d [3];
    logic [2:0]           cd;
    logic signed [OB-1:0] dn [3];
    logic [2:0]           co;
    logic signed [IO_BITS-1:0] upd_reg [3];
    logic                 degen_reg, sat_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        rdt_fmul #(.W(W), .F(F)) u_fd (.a(kp2_reg[i]), .b(t_reg[i]), .p(d[i]), .clip(cd[i]));

        always_comb
        begin
            if (d[i] > OHI)
            begin
                co[i] = 1'b1;
                dn[i] = OB'(OHI);
            end
            else if (d[i] < OLO)
            begin
                co[i] = 1'b1;
                dn[i] = OB'(OLO);
            end
            else
            begin
                co[i] = 1'b0;
                dn[i] = d[i][OB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inf_reg            <= inf_s[W-1:0];
            outf_reg           <= fout;
            kp1_reg            <= kp;
            u1_reg             <= u;
            f1_reg.degen       <= flags_in.degen;
            f1_reg.clip_early  <= flags_in.clip_early;
            f1_reg.clip_late   <= flags_in.clip_late | n_clip | cfin | cfout | inf_s[W];

            t_reg              <= t;
            kp2_reg            <= kp1_reg;
            f2_reg.degen       <= f1_reg.degen;
            f2_reg.clip_early  <= f1_reg.clip_early;
            f2_reg.clip_late   <= f1_reg.clip_late | c2;

            for (int i = 0; i < 3; i++)
                upd_reg[i] <= f2_reg.degen ? '0 : IO_BITS'(dn[i]);
            degen_reg <= f2_reg.degen;
            sat_reg   <= f2_reg.clip_early |
                         (!f2_reg.degen & (f2_reg.clip_late | (|cd) | (|co)));
        end
    end

    assign vld_out    = vld_reg[2];
    assign upd        = upd_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;

endmodule

/* hw/rtl/residual_distribution_triangle_top.sv */
// ----------------------------------------------------------------------------
// residual_distribution_triangle_top
// N / LDA residual distribution over one triangle per item, Q-format fixed
// point, three vertex lanes merged into one shared divide and distribute path.
//
//   channel | signals                                   | transfer
//   --------+-------------------------------------------+-------------------
//   cfg     | cfg_we, cfg_index, cfg_data               | write when cfg_we
//   in      | in_valid/in_ready, vertex*, node_value*   | valid & ready
//   out     | out_valid/out_ready, update*, flags       | valid & ready
//
// One item per cycle sustained while the output is not stalled. Stages: 3 lane
// stages, 1 merge stage, one stage per quotient bit in the reciprocal divider,
// 3 distribution stages. Reset clears the valid pipeline and the configuration
// registers (zero velocity, N scheme). A stall at the output freezes the whole
// pipeline; in_ready is low only while a result waits unaccepted.
// ----------------------------------------------------------------------------
module residual_distribution_triangle_top import rdt_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [IO_BITS-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [IO_BITS-1:0] vertex0_x,
    input  logic signed [IO_BITS-1:0] vertex0_y,
    input  logic signed [IO_BITS-1:0] vertex1_x,
    input  logic signed [IO_BITS-1:0] vertex1_y,
    input  logic signed [IO_BITS-1:0] vertex2_x,
    input  logic signed [IO_BITS-1:0] vertex2_y,
    input  logic signed [IO_BITS-1:0] node_value0,
    input  logic signed [IO_BITS-1:0] node_value1,
    input  logic signed [IO_BITS-1:0] node_value2,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [IO_BITS-1:0] update0,
    output logic signed [IO_BITS-1:0] update1,
    output logic signed [IO_BITS-1:0] update2,
    output logic                      degenerate,
    output logic                      saturated
);

    localparam int     W  = WORD_BITS;
    localparam int     F  = FRAC_BITS;
    localparam int     NB = ((2 * F > W - 1) ? 2 * F : W - 1) + 1;
    localparam int     PW = 8 * W + 3;
    localparam longint HI = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam longint LO = -HI - 64'sd1;

    function automatic logic [W:0] sat_in(input logic signed [IO_BITS-1:0] v);
        logic [W:0] r;
        if (v > HI)
            r = {1'b1, W'(HI)};
        else if (v < LO)
            r = {1'b1, W'(LO)};
        else
            r = {1'b0, W'(v)};
        return r;
    endfunction

    // configuration
    logic signed [IO_BITS-1:0] vel_x_reg, vel_y_reg;
    logic                      mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            mode_reg  <= SCHEME_N;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VELOCITY_X:  vel_x_reg <= cfg_data;
                CFG_VELOCITY_Y:  vel_y_reg <= cfg_data;
                CFG_SCHEME_MODE: mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // entry saturation to the working word
    logic [W:0]          sx [3];
    logic [W:0]          sy [3];
    logic [W:0]          su [3];
    logic [W:0]          svx, svy;
    logic signed [W-1:0] xs [3];
    logic signed [W-1:0] ys [3];
    logic signed [W-1:0] us [3];
    logic                clip_in;

    always_comb
    begin
        sx[0] = sat_in(vertex0_x);
        sy[0] = sat_in(vertex0_y);
        sx[1] = sat_in(vertex1_x);
        sy[1] = sat_in(vertex1_y);
        sx[2] = sat_in(vertex2_x);
        sy[2] = sat_in(vertex2_y);
        su[0] = sat_in(node_value0);
        su[1] = sat_in(node_value1);
        su[2] = sat_in(node_value2);
        svx   = sat_in(vel_x_reg);
        svy   = sat_in(vel_y_reg);
        clip_in = svx[W] | svy[W];
        for (int i = 0; i < 3; i++)
        begin
            xs[i]   = sx[i][W-1:0];
            ys[i]   = sy[i][W-1:0];
            us[i]   = su[i][W-1:0];
            clip_in = clip_in | sx[i][W] | sy[i][W] | su[i][W];
        end
    end

    // lanes, with node values and entry clip delayed alongside
    logic signed [W-1:0] k [3];
    logic [2:0]          lane_clip;
    logic [2:0]          lane_vld_reg;
    logic [2:0]          cin_reg;
    logic signed [W-1:0] ud0_reg [3];
    logic signed [W-1:0] ud1_reg [3];
    logic signed [W-1:0] ud2_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int L = (i + 2) % 3;
        rdt_lane #(.W(W), .F(F)) u_lane (
            .clk  (clk),
            .en   (adv),
            .vx   (svx[W-1:0]),
            .vy   (svy[W-1:0]),
            .xj   (xs[J]),
            .yj   (ys[J]),
            .xl   (xs[L]),
            .yl   (ys[L]),
            .k    (k[i]),
            .clip (lane_clip[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_vld_reg <= '0;
        else if (adv)
            lane_vld_reg <= {lane_vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cin_reg <= {cin_reg[1:0], clip_in};
            ud0_reg <= us;
            ud1_reg <= ud0_reg;
            ud2_reg <= ud1_reg;
        end
    end

    // merge
    logic                m_vld;
    logic [NB-1:0]       m_num;
    logic [W-2:0]        m_den;
    logic signed [W-1:0] m_kp [3];
    logic signed [W-1:0] m_u [3];
    logic signed [W-1:0] m_sneg, m_spos;
    rdt_flags_t          m_flags;

    rdt_merge #(.W(W), .F(F), .NB(NB)) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (lane_vld_reg[2]),
        .k       (k),
        .u       (ud2_reg),
        .clip_in (cin_reg[2] | (|lane_clip)),
        .vld_out (m_vld),
        .num     (m_num),
        .den     (m_den),
        .kp_out  (m_kp),
        .u_out   (m_u),
        .sneg    (m_sneg),
        .spos    (m_spos),
        .flags   (m_flags)
    );

    // reciprocal
    logic [PW-1:0]       pay_in, pay_out;
    logic                d_vld;
    logic [NB-1:0]       d_quo;

    assign pay_in = {m_kp[0], m_kp[1], m_kp[2], m_u[0], m_u[1], m_u[2],
                     m_sneg, m_spos, m_flags};

    rdt_div #(.NB(NB), .DW(W - 1), .PW(PW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (m_vld),
        .num     (m_num),
        .den     (m_den),
        .pay     (pay_in),
        .vld_out (d_vld),
        .quo     (d_quo),
        .pay_out (pay_out)
    );

    logic signed [W-1:0] p_kp [3];
    logic signed [W-1:0] p_u [3];
    logic signed [W-1:0] p_sneg, p_spos;
    rdt_flags_t          p_flags;

    assign {p_kp[0], p_kp[1], p_kp[2], p_u[0], p_u[1], p_u[2],
            p_sneg, p_spos, p_flags} = pay_out;

    // distribution and output register
    logic signed [IO_BITS-1:0] upd [3];

    rdt_dist #(.W(W), .F(F), .NB(NB)) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .mode       (mode_reg),
        .vld_in     (d_vld),
        .q          (d_quo),
        .kp         (p_kp),
        .u          (p_u),
        .sneg       (p_sneg),
        .spos       (p_spos),
        .flags_in   (p_flags),
        .vld_out    (out_valid),
        .upd        (upd),
        .degenerate (degenerate),
        .saturated  (saturated)
    );

    assign update0 = upd[0];
    assign update1 = upd[1];
    assign update2 = upd[2];

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (update0 == '0 && update1 == '0 && update2 == '0))
        else $error("degenerate item with nonzero update");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(update0) && $stable(saturated)))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with no result waiting");

endmodule

/* verif/residual_distribution_triangle_top_tb.sv */
// ----------------------------------------------------------------------------
// residual_distribution_triangle_top_tb
// Drives triangles through the N / LDA residual distribution block under
// random input gaps and output stalls. Each accepted item is predicted by a
// Q16.16 model of the block and the results are compared in order.
// ----------------------------------------------------------------------------
module residual_distribution_triangle_top_tb;
    import rdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = 2 * FRAC + 8;
    localparam int RANDOM_ITEMS = 2000;

    typedef struct packed {
        logic signed [31:0] u0;
        logic signed [31:0] u1;
        logic signed [31:0] u2;
        logic               degen;
        logic               clip;
    } updates_t;

    typedef struct {
        logic signed [31:0] x[3];
        logic signed [31:0] y[3];
        logic signed [31:0] v[3];
    } tri_t;

    typedef struct {
        tri_t     shape;
        bit       known;
        updates_t want;
    } tri_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_VELOCITY_X;
    logic [IO_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [IO_BITS-1:0] vx0 = '0, vy0 = '0, vx1 = '0, vy1 = '0;
    logic signed [IO_BITS-1:0] vx2 = '0, vy2 = '0, nv0 = '0, nv1 = '0, nv2 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [IO_BITS-1:0] update0, update1, update2;
    logic degenerate, saturated;

    residual_distribution_triangle_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .vertex0_x(vx0), .vertex0_y(vy0), .vertex1_x(vx1), .vertex1_y(vy1),
        .vertex2_x(vx2), .vertex2_y(vy2),
        .node_value0(nv0), .node_value1(nv1), .node_value2(nv2),
        .out_valid(out_valid), .out_ready(out_ready),
        .update0(update0), .update1(update1), .update2(update2),
        .degenerate(degenerate), .saturated(saturated)
    );

    always #10 clk = ~clk;

    // predictor copy of the registers
    longint vel_x, vel_y;
    bit     lda_mode;
    bit     clipped;

    updates_t pending_updates[$];
    int  error_count = 0;
    bit  hold_output = 1'b0;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) begin clipped = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin clipped = 1; return -64'sd2147483648; end
        return v;
    endfunction

    // rounded Q product, ties away from zero, saturated
    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] mag;
        longint r;
        bit neg;
        neg = (a < 0) != (b < 0);
        mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        mag = (mag + (128'd1 << (FRAC - 1))) >> FRAC;
        if (!neg && mag > 128'd2147483647) begin clipped = 1; mag = 128'd2147483647; end
        if (neg && mag > 128'd2147483648) begin clipped = 1; mag = 128'd2147483648; end
        r = longint'(mag[63:0]);
        return neg ? -r : r;
    endfunction

    function automatic updates_t distribute(input tri_t t);
        longint k[3], kp[3], d[3];
        longint s, sneg, spos, n, inflow, outflow, diff, nx, ny, tv;
        longint unsigned q;
        updates_t r;
        int j, l;
        clipped = 0;
        s = 0; sneg = 0; spos = 0;
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            l = (i + 2) % 3;
            nx = sat32(longint'(t.y[j]) - longint'(t.y[l]));
            ny = sat32(longint'(t.x[l]) - longint'(t.x[j]));
            k[i] = sat32((qmul(vel_x, nx) + qmul(vel_y, ny)) / 2);
            kp[i] = k[i] > 0 ? k[i] : 0;
            s += kp[i];
        end
        s = sat32(s);
        r.degen = (s <= 0);
        d = '{0, 0, 0};
        if (!r.degen) begin
            q = ((64'd1 << (2 * FRAC)) + longint'(s) / 2) / longint'(s);
            n = sat32(longint'(q));
            for (int i = 0; i < 3; i++) begin
                sneg += qmul(k[i] < 0 ? k[i] : 0, t.v[i]);
                spos += qmul(kp[i], t.v[i]);
            end
            sneg = sat32(sneg);
            spos = sat32(spos);
            inflow = sat32(-qmul(n, sneg));
            outflow = qmul(n, spos);
            diff = sat32(outflow - inflow);
            for (int i = 0; i < 3; i++) begin
                tv = lda_mode ? diff : sat32(longint'(t.v[i]) - inflow);
                d[i] = qmul(kp[i], tv);
            end
        end
        r.u0 = d[0][31:0];
        r.u1 = d[1][31:0];
        r.u2 = d[2][31:0];
        r.clip = clipped;
        return r;
    endfunction

    // leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_VELOCITY_X) vel_x = longint'(signed'(val));
        else if (idx == CFG_VELOCITY_Y) vel_y = longint'(signed'(val));
        else lda_mode = val[0];
    endtask

    task automatic wait_drained;
        while (pending_updates.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(input int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC));
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic tri_t rand_tri;
        tri_t t;
        int style;
        style = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        for (int i = 0; i < 3; i++) begin
            t.x[i] = rand_coord(style);
            t.y[i] = rand_coord(style);
            t.v[i] = rand_coord($urandom_range(0, 4) == 0 ? 0 : 1);
        end
        return t;
    endfunction

    task automatic send_tri(input tri_t t);
        vx0 <= t.x[0]; vy0 <= t.y[0]; vx1 <= t.x[1]; vy1 <= t.y[1];
        vx2 <= t.x[2]; vy2 <= t.y[2];
        nv0 <= t.v[0]; nv1 <= t.v[1]; nv2 <= t.v[2];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_updates.push_back(distribute(t));
    endtask

    task automatic sender_gap;
        int g;
        g = $urandom_range(0, 9);
        if (g >= 7) g = (g == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        else g = 0;
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic tri_t make_tri(input logic [31:0] a, b, c, d, e, f,
                                      input logic [31:0] p, q, r);
        tri_t t;
        t.x = '{a, c, e};
        t.y = '{b, d, f};
        t.v = '{p, q, r};
        return t;
    endfunction

    // receiver
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (pending_updates.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                updates_t w;
                w = pending_updates.pop_front();
                if (update0 !== w.u0) report_mismatch("update0", update0, w.u0);
                if (update1 !== w.u1) report_mismatch("update1", update1, w.u1);
                if (update2 !== w.u2) report_mismatch("update2", update2, w.u2);
                if (degenerate !== w.degen)
                    report_mismatch("degenerate", degenerate, w.degen);
                if (saturated !== w.clip)
                    report_mismatch("saturated", saturated, w.clip);
            end
        end
    end

    initial begin
        int r;
        forever begin
            @(posedge clk);
            if (hold_output) out_ready <= 1'b0;
            else begin
                r = $urandom_range(0, 19);
                out_ready <= (r < 14) || (r == 19 && $urandom_range(0, 1) == 0) ? 1'b1
                             : ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        #50ms;
        $display("residual_distribution_triangle_top_tb NOT OK");
        $finish;
    end

    initial begin
        tri_row_t rows[$];
        tri_row_t row;
        logic [31:0] one;
        one = 32'h0001_0000;
        vel_x = 0; vel_y = 0; lda_mode = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset velocity is zero: every triangle is degenerate
        row.shape = make_tri(0, 0, one, 0, 0, one, one, 2 * one, 3 * one);
        row.known = 1; row.want = '{0, 0, 0, 1'b1, 1'b0};
        rows.push_back(row);
        row.shape = make_tri(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                             0, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
        row.known = 1; row.want = '{0, 0, 0, 1'b1, 1'b1};
        rows.push_back(row);
        foreach (rows[i]) begin
            send_tri(rows[i].shape);
            pending_updates[pending_updates.size() - 1] = rows[i].want;
        end
        in_valid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_reg(CFG_VELOCITY_X, one); write_reg(CFG_VELOCITY_Y, 0); end
                1: write_reg(CFG_SCHEME_MODE, 32'h3);
                2: begin write_reg(CFG_VELOCITY_X, 32'h7fff_ffff);
                         write_reg(CFG_VELOCITY_Y, 32'h8000_0000); end
                3: write_reg(CFG_SCHEME_MODE, 32'h0);
                default: begin
                    write_reg(CFG_VELOCITY_X, rand_coord($urandom_range(1, 2)));
                    write_reg(CFG_VELOCITY_Y, rand_coord($urandom_range(1, 2)));
                    write_reg(CFG_SCHEME_MODE, $urandom);
                end
            endcase
            cfg_we <= 1'b0;
            if (phase < 4) begin
                // directed shapes: both orientations, collinear, extremes
                rows.delete();
                row.known = 0;
                row.shape = make_tri(0, 0, one, 0, 0, one, one, 2 * one, 3 * one);
                rows.push_back(row);
                row.shape = make_tri(0, 0, 0, one, one, 0, 32'hffff_0000, 0, one);
                rows.push_back(row);
                row.shape = make_tri(0, 0, one, one, 2 * one, 2 * one, one, one, one);
                rows.push_back(row);
                row.shape = make_tri(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0,
                                     0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                     32'hffff_ffff);
                rows.push_back(row);
                foreach (rows[i]) send_tri(rows[i].shape);
            end
            if (phase == 5) begin
                // long output stall while input keeps coming
                hold_output = 1'b1;
                fork
                    begin repeat (300) @(posedge clk); hold_output = 1'b0; end
                    for (int i = 0; i < 100; i++) send_tri(rand_tri());
                join
            end
            for (int i = 0; i < RANDOM_ITEMS / 8; i++) begin
                send_tri(rand_tri());
                sender_gap();
                if (i == 200) begin
                    in_valid <= 1'b0;
                    while (pending_updates.size() != 0) @(posedge clk);
                end
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        if (error_count == 0) $display("residual_distribution_triangle_top_tb OK");
        else $display("residual_distribution_triangle_top_tb NOT OK");
        $finish;
    end

endmodule
